// ===== sv/mpto_pkg.sv =====
// ---------------------------------------------------------------------------
// mpto_pkg: shared types and constants for the median peer time offset block
// Field widths, the peer-count threshold, register addresses and the result
// record of the shared offset comparator.
// ---------------------------------------------------------------------------
package mpto_pkg;

  // payload widths
  localparam int KEY_W   = 64;
  localparam int DELTA_W = 48;
  localparam int LIMIT_W = 47;

  // configuration port
  localparam int APB_DW = 64;
  localparam int APB_AW = 3;
  localparam logic [APB_AW-1:0] REG_MAX_OFFSET = 3'd0;

  // smallest peer count for which the median is taken
  localparam int MIN_PEERS = 5;

  // result of the shared signed comparator
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

// ===== sv/mpto_ram.sv =====
// ---------------------------------------------------------------------------
// mpto_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module mpto_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/mpto_cmp.sv =====
// ---------------------------------------------------------------------------
// mpto_cmp: shared signed offset comparator
// Gives less-than and equal for two signed offsets; used for ranking and
// for both clamp bounds.
// ---------------------------------------------------------------------------
module mpto_cmp (
  input  logic signed [mpto_pkg::DELTA_W-1:0] op_a,
  input  logic signed [mpto_pkg::DELTA_W-1:0] op_b,
  output mpto_pkg::cmp_res_t                  res
);

  // signed compare
  assign res.lt = (op_a < op_b);
  assign res.eq = (op_a == op_b);

endmodule

// ===== sv/median_peer_time_offset.sv =====
// ---------------------------------------------------------------------------
// median_peer_time_offset: peer clock offset table with median selection
// Keeps peer keys and offsets, takes the clamped median as node offset.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries a peer key and its offset in
//   ms; zero removes the peer. Each transfer gives exactly one result on the
//   output channel (out_valid/out_stall). The limit register sits at byte
//   address 0 of the APB port; it must be written only while the block is
//   idle, which the block itself does not enforce. in_stall is high from
//   the accepted transfer until its result is loaded into the output
//   register; one item is processed at a time.
//   Steps: key lookup sweep over the key RAM, update, count check; when the
//   median is taken, per examined slot a skip for an empty slot, or for a
//   held one an offset load and a rank sweep over the offset RAM with the
//   shared comparator; then the clamp; last the output register is loaded.
//   The rank sweep dominates the processing time.
//   A finished result waits in the output register while out_stall is high;
//   a next item may already be accepted and waits before its own load.
//   Reset clears the table valid bits, peer count, node offset and limit;
//   RAM contents are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
module median_peer_time_offset #(
  parameter int MAX_PEERS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mpto_pkg::APB_AW-1:0]         paddr,
  input  logic [mpto_pkg::APB_DW-1:0]         pwdata,
  output logic [mpto_pkg::APB_DW-1:0]         prdata,
  output logic                                pready,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mpto_pkg::KEY_W-1:0]          in_peer_key,
  input  logic signed [mpto_pkg::DELTA_W-1:0] in_delta_ms,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_recomputed,
  output logic signed [mpto_pkg::DELTA_W-1:0] out_current_offset_ms,
  output logic                                out_desync,
  output logic [mpto_pkg::KEY_W-1:0]          out_desync_peer,
  output logic                                out_dropped
);

  localparam int IDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int CNT_W = $clog2(MAX_PEERS + 1);
  localparam logic [CNT_W-1:0] NPEER = CNT_W'(MAX_PEERS);
  localparam logic [CNT_W-1:0] MINP  = CNT_W'(mpto_pkg::MIN_PEERS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_CHECK,
    S_MED_I,
    S_MED_LD,
    S_RANK,
    S_RANK_END,
    S_CLAMP_HI,
    S_CLAMP_LO,
    S_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic [mpto_pkg::LIMIT_W-1:0] max_r;

  // table control
  logic [MAX_PEERS-1:0] valid_r;
  logic [CNT_W-1:0]     count_r;
  logic signed [mpto_pkg::DELTA_W-1:0] node_r;

  // item registers
  logic [mpto_pkg::KEY_W-1:0]          key_in_r;
  logic signed [mpto_pkg::DELTA_W-1:0] delta_in_r;

  // sweep pipeline
  logic [CNT_W-1:0] cnt_r;
  logic             p_vld_r;
  logic [IDX_W-1:0] p_idx_r;
  logic             sweep_done;

  // lookup results
  logic             found_r;
  logic [IDX_W-1:0] found_idx_r;
  logic             free_r;
  logic [IDX_W-1:0] free_idx_r;

  // median search
  logic [CNT_W-1:0] i_r;
  logic [CNT_W-1:0] rank_r;
  logic [CNT_W-1:0] target_r;
  logic signed [mpto_pkg::DELTA_W-1:0] cur_r;
  logic             hi_r;
  logic [mpto_pkg::KEY_W-1:0] key_r;

  // result flags
  logic recomp_r;
  logic desync_r;
  logic dropped_r;

  // output register
  logic                                out_valid_r;
  logic                                out_recomp_r;
  logic signed [mpto_pkg::DELTA_W-1:0] out_offset_r;
  logic                                out_desync_r;
  logic [mpto_pkg::KEY_W-1:0]          out_peer_r;
  logic                                out_dropped_r;

  // memories and shared comparator
  logic                                rd_addr_sel;
  logic [IDX_W-1:0]                    rd_addr;
  logic [IDX_W-1:0]                    wr_addr;
  logic                                key_we;
  logic                                delta_we;
  logic [mpto_pkg::KEY_W-1:0]          key_rdata;
  logic [mpto_pkg::DELTA_W-1:0]        delta_rdata;
  logic signed [mpto_pkg::DELTA_W-1:0] delta_rd_s;
  logic signed [mpto_pkg::DELTA_W-1:0] lim_s;
  logic signed [mpto_pkg::DELTA_W-1:0] neg_lim_s;
  logic signed [mpto_pkg::DELTA_W-1:0] cmp_a;
  logic signed [mpto_pkg::DELTA_W-1:0] cmp_b;
  mpto_pkg::cmp_res_t                  cmp_res;
  logic                                cfg_wr;
  logic                                rank_hit;
  logic                                out_free;

  // apb register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == mpto_pkg::REG_MAX_OFFSET);
  assign prdata = (paddr == mpto_pkg::REG_MAX_OFFSET)
                  ? mpto_pkg::APB_DW'(max_r) : '0;

  // handshake
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_recomputed        = out_recomp_r;
  assign out_current_offset_ms = out_offset_r;
  assign out_desync            = out_desync_r;
  assign out_desync_peer       = out_peer_r;
  assign out_dropped           = out_dropped_r;

  // clamp bounds
  assign lim_s      = $signed({1'b0, max_r});
  assign neg_lim_s  = -lim_s;
  assign delta_rd_s = $signed(delta_rdata);

  // ram read address: slot under test or sweep pointer
  assign rd_addr_sel = (state_r == S_MED_I) || (state_r == S_CLAMP_HI);
  assign rd_addr     = rd_addr_sel ? i_r[IDX_W-1:0] : cnt_r[IDX_W-1:0];

  // table writes
  assign key_we   = (state_r == S_UPDATE) && (delta_in_r != '0) && !found_r && free_r;
  assign delta_we = (state_r == S_UPDATE) && (delta_in_r != '0) && (found_r || free_r);
  assign wr_addr  = found_r ? found_idx_r : free_idx_r;

  mpto_ram #(
    .WIDTH (mpto_pkg::KEY_W),
    .DEPTH (MAX_PEERS)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (wr_addr),
    .wdata (key_in_r),
    .raddr (rd_addr),
    .rdata (key_rdata)
  );

  mpto_ram #(
    .WIDTH (mpto_pkg::DELTA_W),
    .DEPTH (MAX_PEERS)
  ) u_delta_ram (
    .clk   (clk),
    .we    (delta_we),
    .waddr (wr_addr),
    .wdata (delta_in_r),
    .raddr (rd_addr),
    .rdata (delta_rdata)
  );

  // comparator operand selection
  always_comb begin
    case (state_r)
      S_CLAMP_HI: begin
        cmp_a = lim_s;
        cmp_b = cur_r;
      end
      S_CLAMP_LO: begin
        cmp_a = cur_r;
        cmp_b = neg_lim_s;
      end
      default: begin
        cmp_a = delta_rd_s;
        cmp_b = cur_r;
      end
    endcase
  end

  mpto_cmp u_cmp (
    .op_a (cmp_a),
    .op_b (cmp_b),
    .res  (cmp_res)
  );

  // entry in sweep ranks before the slot under test
  assign rank_hit = p_vld_r && valid_r[p_idx_r] && (p_idx_r != i_r[IDX_W-1:0]) &&
                    (cmp_res.lt || (cmp_res.eq && (p_idx_r < i_r[IDX_W-1:0])));

  assign sweep_done = (cnt_r == NPEER) && !p_vld_r;

  // sequencer, table control and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_r       <= '0;
      valid_r     <= '0;
      count_r     <= '0;
      node_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        max_r <= pwdata[mpto_pkg::LIMIT_W-1:0];
      end

      // output transfer retires the held result unless a new one loads
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      // shared sweep pointer
      if (state_r == S_SCAN || state_r == S_RANK) begin
        if (cnt_r != NPEER) begin
          cnt_r   <= cnt_r + 1'b1;
          p_vld_r <= 1'b1;
          p_idx_r <= cnt_r[IDX_W-1:0];
        end else begin
          p_vld_r <= 1'b0;
        end
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            key_in_r   <= in_peer_key;
            delta_in_r <= in_delta_ms;
            cnt_r      <= '0;
            p_vld_r    <= 1'b0;
            found_r    <= 1'b0;
            free_r     <= 1'b0;
            recomp_r   <= 1'b0;
            desync_r   <= 1'b0;
            dropped_r  <= 1'b0;
            state_r    <= S_SCAN;
          end
        end

        // key lookup and lowest free slot
        S_SCAN: begin
          if (p_vld_r) begin
            if (valid_r[p_idx_r]) begin
              if (!found_r && (key_rdata == key_in_r)) begin
                found_r     <= 1'b1;
                found_idx_r <= p_idx_r;
              end
            end else if (!free_r) begin
              free_r     <= 1'b1;
              free_idx_r <= p_idx_r;
            end
          end
          if (sweep_done) begin
            state_r <= S_UPDATE;
          end
        end

        // insert, overwrite or remove
        S_UPDATE: begin
          if (delta_in_r != '0) begin
            if (!found_r) begin
              if (free_r) begin
                valid_r[free_idx_r] <= 1'b1;
                count_r             <= count_r + 1'b1;
              end else begin
                dropped_r <= 1'b1;
              end
            end
          end else if (found_r) begin
            valid_r[found_idx_r] <= 1'b0;
            count_r              <= count_r - 1'b1;
          end
          state_r <= S_CHECK;
        end

        // median only for an odd count of at least five
        S_CHECK: begin
          if ((count_r >= MINP) && count_r[0]) begin
            target_r <= count_r >> 1;
            i_r      <= '0;
            state_r  <= S_MED_I;
          end else begin
            state_r <= S_DONE;
          end
        end

        // next held slot as median candidate
        S_MED_I: begin
          if (i_r == NPEER) begin
            state_r <= S_DONE;
          end else if (valid_r[i_r[IDX_W-1:0]]) begin
            state_r <= S_MED_LD;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end

        S_MED_LD: begin
          cur_r   <= delta_rd_s;
          cnt_r   <= '0;
          p_vld_r <= 1'b0;
          rank_r  <= '0;
          state_r <= S_RANK;
        end

        // count entries ranking before the candidate
        S_RANK: begin
          if (rank_hit) begin
            rank_r <= rank_r + 1'b1;
          end
          if (sweep_done) begin
            state_r <= S_RANK_END;
          end
        end

        S_RANK_END: begin
          if (rank_r == target_r) begin
            state_r <= S_CLAMP_HI;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_MED_I;
          end
        end

        // upper bound, key read of the median slot
        S_CLAMP_HI: begin
          hi_r    <= cmp_res.lt;
          state_r <= S_CLAMP_LO;
        end

        // lower bound and node offset update
        S_CLAMP_LO: begin
          key_r    <= key_rdata;
          recomp_r <= 1'b1;
          desync_r <= hi_r || cmp_res.lt;
          if (hi_r) begin
            node_r <= lim_s;
          end else if (cmp_res.lt) begin
            node_r <= neg_lim_s;
          end else begin
            node_r <= cur_r;
          end
          state_r <= S_DONE;
        end

        // load result once the output register is free
        S_DONE: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_recomp_r  <= recomp_r;
            out_offset_r  <= node_r;
            out_desync_r  <= desync_r;
            out_peer_r    <= desync_r ? key_r : '0;
            out_dropped_r <= dropped_r;
            state_r       <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_accept_starts_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_SCAN))
    else $error("accepted transfer did not start the key lookup");

  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(valid_r) == int'(count_r)))
    else $error("peer count differs from number of held slots");

  a_desync_needs_median: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_desync) |-> out_recomputed)
    else $error("desync reported without a median");

endmodule
